>>> rtl/core/rational_arithmetic_unit_macros.svh
// Assertion macros shared by the checker of the rational arithmetic unit.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("rational_arithmetic_unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("rational_arithmetic_unit: next-cycle check failed");

`endif

>>> rtl/core/rau_pkg.sv
// Package of the rational arithmetic unit: operation and status codes,
// controller states, datapath commands and the datapath status struct.
// No dependencies.
`timescale 1ns / 1ps

package rau_pkg;

	localparam int MAG_W = 64;

	localparam logic [3:0] FN_ADD = 4'd0;
	localparam logic [3:0] FN_SUB = 4'd1;
	localparam logic [3:0] FN_MUL = 4'd2;
	localparam logic [3:0] FN_DIV = 4'd3;
	localparam logic [3:0] FN_EQ  = 4'd4;
	localparam logic [3:0] FN_NE  = 4'd5;
	localparam logic [3:0] FN_GT  = 4'd6;
	localparam logic [3:0] FN_LT  = 4'd7;
	localparam logic [3:0] FN_GE  = 4'd8;
	localparam logic [3:0] FN_LE  = 4'd9;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULA,
		S_MULB,
		S_MULC,
		S_COMB,
		S_CHECK,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MUL_A,
		CMD_MUL_B,
		CMD_MUL_C,
		CMD_COMBINE,
		CMD_FAST,
		CMD_GCD_INIT,
		CMD_GCD_STEP,
		CMD_DIVN_INIT,
		CMD_DIV_STEP,
		CMD_DIVD_INIT,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic fast;
		logic gcd_done;
		logic div_done;
	} dp_status_t;

endpackage

>>> rtl/core/rau_ctrl.sv
// Controller of the rational arithmetic unit: sequences the datapath.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rau_pkg::dp_status_t dp_st,
	output rau_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                done
);
	import rau_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			S_IDLE, S_OUT: begin
				busy = 1'b0;
				done = (state_q == S_OUT);
				if (start) begin
					cmd     = CMD_LOAD;
					state_d = S_MULA;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MULA: begin
				cmd     = CMD_MUL_A;
				state_d = S_MULB;
			end
			S_MULB: begin
				cmd     = CMD_MUL_B;
				state_d = S_MULC;
			end
			S_MULC: begin
				cmd     = CMD_MUL_C;
				state_d = S_COMB;
			end
			S_COMB: begin
				cmd     = CMD_COMBINE;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (dp_st.fast) begin
					cmd     = CMD_FAST;
					state_d = S_OUT;
				end else begin
					cmd     = CMD_GCD_INIT;
					state_d = S_GCD;
				end
			end
			S_GCD: begin
				if (dp_st.gcd_done) begin
					cmd     = CMD_DIVN_INIT;
					state_d = S_DIVN;
				end else begin
					cmd = CMD_GCD_STEP;
				end
			end
			S_DIVN: begin
				if (dp_st.div_done) begin
					cmd     = CMD_DIVD_INIT;
					state_d = S_DIVD;
				end else begin
					cmd = CMD_DIV_STEP;
				end
			end
			S_DIVD: begin
				if (dp_st.div_done) begin
					cmd     = CMD_FINISH;
					state_d = S_OUT;
				end else begin
					cmd = CMD_DIV_STEP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/rau_dp.sv
// Datapath of the rational arithmetic unit: shared multiplier, signed
// combine, binary GCD and restoring divider. Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_dp #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                clk,
	input  rau_pkg::cmd_t       cmd,
	input  logic [3:0]          func,
	input  logic signed [31:0]  a_numer,
	input  logic signed [31:0]  a_denom,
	input  logic signed [31:0]  b_numer,
	input  logic signed [31:0]  b_denom,
	output rau_pkg::dp_status_t dp_st,
	output logic signed [63:0]  res_numer,
	output logic [62:0]         res_denom,
	output logic                cmp_true,
	output logic [1:0]          status
);
	import rau_pkg::*;

	localparam int OW = OPERAND_WIDTH;

	logic [3:0]        func_q;
	logic              bad_func_q, zden_op_q;
	logic [OW-1:0]     an_q, ad_q, bn_q, bd_q;
	logic              an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [MAG_W-1:0]  pa_q, pb_q, pc_q;
	logic              pa_neg_q, pb_neg_q, pc_neg_q;
	logic [MAG_W-1:0]  num_q, den_q;
	logic              num_neg_q, den_neg_q;
	logic [MAG_W-1:0]  ga_q, gb_q;
	logic [5:0]        k_q;
	logic [MAG_W-1:0]  dvs_q, quo_q, rem_q, nm_q;
	logic [6:0]        cnt_q;

	// Operand fields cut to OPERAND_WIDTH bits; the magnitudes are taken at load.
	logic [OW-1:0] an_v, ad_v, bn_v, bd_v;
	assign an_v = a_numer[OW-1:0];
	assign ad_v = a_denom[OW-1:0];
	assign bn_v = b_numer[OW-1:0];
	assign bd_v = b_denom[OW-1:0];

	logic is_cmp, is_mul, is_div, neg_b;
	assign is_cmp = (func_q >= FN_EQ) && (func_q <= FN_LE);
	assign is_mul = (func_q == FN_MUL);
	assign is_div = (func_q == FN_DIV);
	assign neg_b  = (func_q == FN_SUB) || is_cmp;

	// Shared multiplier.
	logic [OW-1:0]     mx, my;
	logic              mxn, myn;
	logic [2*OW-1:0]   prod;
	logic [MAG_W-1:0]  prod64;
	logic              prod_neg;

	always_comb begin
		mx  = ad_q;
		mxn = ad_neg_q;
		my  = bd_q;
		myn = bd_neg_q;
		case (cmd)
			CMD_MUL_A: begin
				mx  = an_q;
				mxn = an_neg_q;
				my  = is_mul ? bn_q : bd_q;
				myn = is_mul ? bn_neg_q : bd_neg_q;
			end
			CMD_MUL_B: begin
				my  = bn_q;
				myn = bn_neg_q;
			end
			default: begin
			end
		endcase
	end

	assign prod     = mx * my;
	assign prod64   = MAG_W'(prod);
	assign prod_neg = (mxn ^ myn) && (prod != '0);

	// Signed-magnitude combine of the two cross products.
	logic              bneg_eff;
	logic [MAG_W-1:0]  sum_mag;
	logic              sum_neg;

	always_comb begin
		bneg_eff = (pb_neg_q ^ neg_b) && (pb_q != '0);
		if (pa_neg_q == bneg_eff) begin
			sum_mag = pa_q + pb_q;
			sum_neg = pa_neg_q;
		end else if (pa_q >= pb_q) begin
			sum_mag = pa_q - pb_q;
			sum_neg = pa_neg_q;
		end else begin
			sum_mag = pb_q - pa_q;
			sum_neg = bneg_eff;
		end
		if (sum_mag == '0) begin
			sum_neg = 1'b0;
		end
	end

	// Comparison outcome from the sign of the difference.
	logic sgn_zero, sgn_neg, cmp_bit;
	assign sgn_zero = (num_q == '0);
	assign sgn_neg  = !sgn_zero && (num_neg_q != den_neg_q);

	always_comb begin
		case (func_q)
			FN_EQ:   cmp_bit = sgn_zero;
			FN_NE:   cmp_bit = !sgn_zero;
			FN_GT:   cmp_bit = !sgn_zero && !sgn_neg;
			FN_LT:   cmp_bit = sgn_neg;
			FN_GE:   cmp_bit = !sgn_neg;
			FN_LE:   cmp_bit = sgn_zero || sgn_neg;
			default: cmp_bit = 1'b0;
		endcase
	end

	// Restoring divider step.
	logic [MAG_W:0] trial;
	assign trial = {rem_q, quo_q[MAG_W-1]} - {1'b0, dvs_q};

	logic res_neg, ovf;
	assign res_neg = num_neg_q ^ den_neg_q;
	assign ovf     = res_neg ? (nm_q[MAG_W-1] && (nm_q[MAG_W-2:0] != '0)) : nm_q[MAG_W-1];

	assign dp_st.fast     = bad_func_q || zden_op_q || is_cmp || (den_q == '0) || (num_q == '0);
	assign dp_st.gcd_done = (ga_q == '0) || (gb_q == '0);
	assign dp_st.div_done = cnt_q[6];

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				func_q     <= func;
				bad_func_q <= (func > FN_LE);
				zden_op_q  <= (ad_v == '0) || (bd_v == '0);
				an_neg_q   <= an_v[OW-1];
				ad_neg_q   <= ad_v[OW-1];
				bn_neg_q   <= bn_v[OW-1];
				bd_neg_q   <= bd_v[OW-1];
				an_q       <= an_v[OW-1] ? (OW'(0) - an_v) : an_v;
				ad_q       <= ad_v[OW-1] ? (OW'(0) - ad_v) : ad_v;
				bn_q       <= bn_v[OW-1] ? (OW'(0) - bn_v) : bn_v;
				bd_q       <= bd_v[OW-1] ? (OW'(0) - bd_v) : bd_v;
			end
			CMD_MUL_A: begin
				pa_q     <= prod64;
				pa_neg_q <= prod_neg;
			end
			CMD_MUL_B: begin
				pb_q     <= prod64;
				pb_neg_q <= prod_neg;
			end
			CMD_MUL_C: begin
				pc_q     <= prod64;
				pc_neg_q <= prod_neg;
			end
			CMD_COMBINE: begin
				if (is_mul || is_div) begin
					num_q     <= pa_q;
					num_neg_q <= pa_neg_q;
				end else begin
					num_q     <= sum_mag;
					num_neg_q <= sum_neg;
				end
				den_q     <= is_div ? pb_q : pc_q;
				den_neg_q <= is_div ? pb_neg_q : pc_neg_q;
			end
			CMD_FAST: begin
				res_numer <= '0;
				res_denom <= 63'd1;
				cmp_true  <= 1'b0;
				status    <= ST_OK;
				if (!bad_func_q) begin
					if (zden_op_q) begin
						status <= ST_ZDEN;
					end else if (is_cmp) begin
						cmp_true <= cmp_bit;
					end else if (den_q == '0) begin
						status <= ST_ZDEN;
					end
				end
			end
			CMD_GCD_INIT: begin
				ga_q <= num_q;
				gb_q <= den_q;
				k_q  <= '0;
			end
			CMD_GCD_STEP: begin
				if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					k_q  <= k_q + 6'd1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
			end
			CMD_DIVN_INIT: begin
				dvs_q <= (ga_q | gb_q) << k_q;
				quo_q <= num_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			CMD_DIV_STEP: begin
				if (!trial[MAG_W]) begin
					rem_q <= trial[MAG_W-1:0];
					quo_q <= {quo_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[MAG_W-2:0], quo_q[MAG_W-1]};
					quo_q <= {quo_q[MAG_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 7'd1;
			end
			CMD_DIVD_INIT: begin
				nm_q  <= quo_q;
				quo_q <= den_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			CMD_FINISH: begin
				cmp_true <= 1'b0;
				if (ovf) begin
					res_numer <= '0;
					res_denom <= 63'd1;
					status    <= ST_OVF;
				end else begin
					res_numer <= res_neg ? $signed(MAG_W'(0) - nm_q) : $signed(nm_q);
					res_denom <= quo_q[62:0];
					status    <= ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: joins controller and datapath.
// Depends on rau_pkg, rau_ctrl and rau_dp.
`timescale 1ns / 1ps

// Usage. A request (func and the four operand fields) is taken at a rising
// clock edge where start is high and busy is low. Each request yields exactly
// one result, shown on res_numer, res_denom, cmp_true and status for a single
// cycle while done is high; the receiver cannot stall, so it must capture the
// result in that cycle. busy is low in the done cycle, so the next request may
// be issued while a result is on the ports.
// Comparisons, invalid codes and early zero cases finish after the load, the
// three multiply steps, the combine and the check. Add, subtract, multiply
// and divide then run a binary GCD, one shift or subtract per cycle, and two
// 64-step restoring divisions that share one divider. One request is in
// flight at a time; the GCD loop and the shared divider set the rate.
// Reset (arst_n low) returns the controller to idle at once; no result is
// pending afterwards and the result ports hold stale data until done.
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         func,
	input  logic signed [31:0] a_numer,
	input  logic signed [31:0] a_denom,
	input  logic signed [31:0] b_numer,
	input  logic signed [31:0] b_denom,
	output logic               done,
	output logic signed [63:0] res_numer,
	output logic [62:0]        res_denom,
	output logic               cmp_true,
	output logic [1:0]         status
);
	import rau_pkg::*;

	// Command and status between the sequencer and the datapath.
	cmd_t       cmd;
	dp_status_t dp_st;

	rau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.dp_st  (dp_st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds operands, products, GCD and divider registers and
	// the result registers, written when the controller finishes a request.
	rau_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.func      (func),
		.a_numer   (a_numer),
		.a_denom   (a_denom),
		.b_numer   (b_numer),
		.b_denom   (b_denom),
		.dp_st     (dp_st),
		.res_numer (res_numer),
		.res_denom (res_denom),
		.cmp_true  (cmp_true),
		.status    (status)
	);

endmodule

>>> rtl/core/rau_checker.sv
// Port-level checker of the rational arithmetic unit and its bind.
// Depends on rau_pkg, rational_arithmetic_unit_macros.svh and the top level.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_macros.svh"

module rau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [63:0] res_numer,
	input logic [62:0]        res_denom,
	input logic               cmp_true,
	input logic [1:0]         status
);
	import rau_pkg::*;

	// An accepted request keeps the block busy in the next cycle.
	`RAU_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	// A result lasts one cycle.
	`RAU_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done)
	// Error results and comparisons carry the fraction 0/1.
	`RAU_ASSERT_IMP(a_err_zero, clk, arst_n, done && (status != ST_OK || cmp_true),
		res_numer == 64'sd0 && res_denom == 63'd1)
	// The status code is a defined one and the denominator is positive.
	`RAU_ASSERT_IMP(a_status_ok, clk, arst_n, done, status <= ST_OVF && res_denom != 63'd0)
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
